[rtl/sust_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sust_pkg: shared types and constants of the sorted unique set table
// Command and status codes, the broadcast control word and the per-cell
// view that neighbors and the top level read.
// ----------------------------------------------------------------------------
package sust_pkg;

    localparam int KEY_W        = 32;
    localparam int CMD_W        = 3;
    localparam int COUNT_OUT_W  = 5;
    localparam int STATUS_W     = 2;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_LOOKUP = 3'd2,
        CMD_POP    = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Control broadcast to every cell; each strobe is already qualified
    // by an accepted beat.
    typedef struct packed {
        logic                    do_insert;
        logic                    do_remove;
        logic                    do_pop;
        logic                    do_clear;
        logic signed [KEY_W-1:0] key;
    } ctrl_t;

    // What one cell shows to its neighbors and to the top level.
    typedef struct packed {
        logic                    valid;
        logic                    gt;
        logic                    eq;
        logic signed [KEY_W-1:0] value;
        logic                    valid_next;
        logic signed [KEY_W-1:0] value_next;
    } cell_t;

endpackage

[rtl/sorted_unique_set_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_set_table: bounded sorted set of signed 32-bit values
// Insert, remove, lookup, pop-smallest and clear on a chain of compare and
// shift cells; one result beat per command beat.
// ----------------------------------------------------------------------------
//  port group | dir | beat contents
//  -----------+-----+--------------------------------------------------
//  s_*        | in  | cmd, key_value
//  m_*        | out | was_present, out_value, entry_count, status
//
//  A command beat updates every cell in the cycle it is taken; the result
//  sits in the output register from the next cycle on. One beat per cycle
//  is taken while the output register is empty or being drained; the
//  single broadcast compare across the cell chain sets that figure.
//  Reset clears all valid bits and the count; no clearing pass is needed.
//  A stalled result blocks new commands only while it is not taken.
// ----------------------------------------------------------------------------
module sorted_unique_set_table #(
    parameter int CAPACITY = sust_pkg::CAPACITY_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [sust_pkg::CMD_W-1:0]               s_cmd,
    input  logic signed [sust_pkg::KEY_W-1:0]        s_key_value,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic                                     m_was_present,
    output logic signed [sust_pkg::KEY_W-1:0]        m_out_value,
    output logic [sust_pkg::COUNT_OUT_W-1:0]         m_entry_count,
    output logic [sust_pkg::STATUS_W-1:0]            m_status
);
    import sust_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    cell_t                cells [CAPACITY];
    logic [CAPACITY-1:0]  valid_vec;
    logic [CAPACITY-1:0]  eq_vec;
    ctrl_t                ctrl;
    cmd_t                 cmd;
    logic                 accept;
    logic                 present;
    logic                 full;
    logic                 empty;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    logic                     m_valid_reg;
    logic                     was_present_reg;
    logic                     was_present_next;
    logic signed [KEY_W-1:0]  out_value_reg;
    logic signed [KEY_W-1:0]  out_value_next;
    logic [COUNT_OUT_W-1:0]   entry_count_reg;
    status_t                  status_reg;
    status_t                  status_next;

    // Chain boundaries: the left end acts as a valid smaller value,
    // the right end as an empty slot
    cell_t left_edge;
    cell_t right_edge;

    assign left_edge  = '{valid: 1'b1, gt: 1'b0, eq: 1'b0, value: '0,
                          valid_next: 1'b1, value_next: '0};
    assign right_edge = '{valid: 1'b0, gt: 1'b0, eq: 1'b0, value: '0,
                          valid_next: 1'b0, value_next: '0};

    // Handshake: take a beat whenever the output register can move
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign cmd     = cmd_t'(s_cmd);

    // Gather flags across the chain
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            valid_vec[i] = cells[i].valid;
            eq_vec[i]    = cells[i].eq;
        end
    end

    assign present = |eq_vec;
    assign full    = valid_vec[CAPACITY-1];
    assign empty   = !valid_vec[0];

    // Decode the command into cell strobes
    always_comb begin
        ctrl.do_insert = 1'b0;
        ctrl.do_remove = 1'b0;
        ctrl.do_pop    = 1'b0;
        ctrl.do_clear  = 1'b0;
        ctrl.key       = s_key_value;
        if (accept) begin
            unique case (cmd)
                CMD_INSERT: ctrl.do_insert = !present && !full;
                CMD_REMOVE: ctrl.do_remove = present;
                CMD_POP:    ctrl.do_pop    = !empty;
                CMD_CLEAR:  ctrl.do_clear  = 1'b1;
                default:    ;
            endcase
        end
    end

    // Cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        cell_t left_nb;
        cell_t right_nb;
        if (g == 0) begin : g_first
            assign left_nb = left_edge;
        end else begin : g_mid_l
            assign left_nb = cells[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_nb = right_edge;
        end else begin : g_mid_r
            assign right_nb = cells[g+1];
        end
        sust_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .left_in  (left_nb),
            .right_in (right_nb),
            .cell_out (cells[g])
        );
    end

    // Track the fill count
    always_comb begin
        count_next = count_reg;
        if (ctrl.do_clear) begin
            count_next = '0;
        end else if (ctrl.do_insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.do_remove || ctrl.do_pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Build the result beat
    always_comb begin
        was_present_next = 1'b0;
        status_next      = ST_OK;
        out_value_next   = cells[0].valid_next ? cells[0].value_next : '0;
        case (cmd)
            CMD_INSERT: begin
                was_present_next = present;
                if (!present && full) begin
                    status_next = ST_FULL;
                end
            end
            CMD_REMOVE, CMD_LOOKUP: begin
                was_present_next = present;
            end
            CMD_POP: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    out_value_next = cells[0].value;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Load result payload on an accepted beat
    always_ff @(posedge aclk) begin
        if (accept) begin
            was_present_reg <= was_present_next;
            out_value_reg   <= out_value_next;
            entry_count_reg <= COUNT_OUT_W'(count_next);
            status_reg      <= status_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_was_present = was_present_reg;
    assign m_out_value   = out_value_reg;
    assign m_entry_count = entry_count_reg;
    assign m_status      = status_reg;

    // Count agrees with the valid bits
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        32'($countones(valid_vec)) == 32'(count_reg))
        else $error("fill count differs from valid cells");

    // Valid cells form a prefix of the chain
    a_valid_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_vec + CAPACITY'(1)) & valid_vec) == '0)
        else $error("valid cells are not a prefix");

    // A key matches at most one cell
    a_unique_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(eq_vec))
        else $error("duplicate value in table");

    // An accepted insert on a full table leaves the count unchanged
    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd == CMD_INSERT && full && !present) |=> $stable(count_reg))
        else $error("insert into full table changed the count");

endmodule

[rtl/sust_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sust_cell: one slot of the sorted chain
// Holds one value and its valid bit, compares it against the broadcast key
// and takes its neighbor's value when the chain shifts.
// ----------------------------------------------------------------------------
module sust_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  sust_pkg::ctrl_t ctrl,
    input  sust_pkg::cell_t left_in,
    input  sust_pkg::cell_t right_in,
    output sust_pkg::cell_t cell_out
);
    import sust_pkg::*;

    logic                    valid_reg;
    logic                    valid_next;
    logic signed [KEY_W-1:0] value_reg;
    logic signed [KEY_W-1:0] value_next;
    logic                    gt;
    logic                    eq;

    // Compare stored value against the key
    assign gt = valid_reg && (value_reg > ctrl.key);
    assign eq = valid_reg && (value_reg == ctrl.key);

    // Pick the next slot contents
    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.do_clear) begin
            valid_next = 1'b0;
        end else if (ctrl.do_insert) begin
            if (left_in.gt) begin
                // shift up: larger values move one slot right
                valid_next = 1'b1;
                value_next = left_in.value;
            end else if (gt || (!valid_reg && left_in.valid)) begin
                // first slot past the smaller values takes the key
                valid_next = 1'b1;
                value_next = ctrl.key;
            end
        end else if (ctrl.do_pop || (ctrl.do_remove && (gt || eq))) begin
            // shift down: close the gap from the right
            valid_next = right_in.valid;
            value_next = right_in.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload without reset
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign cell_out.valid      = valid_reg;
    assign cell_out.gt         = gt;
    assign cell_out.eq         = eq;
    assign cell_out.value      = value_reg;
    assign cell_out.valid_next = valid_next;
    assign cell_out.value_next = value_next;

endmodule
